// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the day-count to date converter.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop)
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond)

`endif

`endif

// ===== rtl/dtcd_pkg.sv =====
// Shared types and constants for the day-count to civil date converter.
// No dependencies.
package dtcd_pkg;

  // Converter sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH
  } cvt_state_t;

  // Calendar constants
  localparam int unsigned YEAR_W      = 13;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned YLEN_W      = 9;

  localparam int unsigned EPOCH_YEAR  = 1970;
  localparam int unsigned LEAP_CYCLE  = 4;
  localparam int unsigned CENTURY     = 100;
  localparam int unsigned QUAD_CENT   = 400;
  localparam int unsigned DAYS_COMMON = 365;
  localparam int unsigned DAYS_LEAP   = 366;

  localparam int unsigned MOD4_W   = $clog2(LEAP_CYCLE);
  localparam int unsigned MOD100_W = $clog2(CENTURY);
  localparam int unsigned MOD400_W = $clog2(QUAD_CENT);

  // Residues of the epoch year
  localparam logic [MOD4_W-1:0]   EPOCH_MOD4   = MOD4_W'(EPOCH_YEAR % LEAP_CYCLE);
  localparam logic [MOD100_W-1:0] EPOCH_MOD100 = MOD100_W'(EPOCH_YEAR % CENTURY);
  localparam logic [MOD400_W-1:0] EPOCH_MOD400 = MOD400_W'(EPOCH_YEAR % QUAD_CENT);

  // Month codes
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // Short queue between the accept side and the converter
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Days in month m; February depends on the leap flag
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MON_FEB:                            len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default:                            len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/days_to_civil_date.sv =====
// Top level: converts a count of days since 1970-01-01 to year/month/day.
// Depends on dtcd_pkg, dtcd_front, dtcd_back.
//
//  Channel   Signals                    Handshake
//  --------  -------------------------  ------------------------------------
//  command   start, day_count, busy     taken at an edge with start && !busy
//  result    done, year, month, day     one-cycle strobe, cannot be held off
//
// Each transaction takes one year-subtractor step per whole year past
// 1970, then up to eleven month steps, plus dequeue and output.
// A two-entry queue sits in front of the converter, so busy rises only
// when two transactions wait behind the one in progress.
// Synchronous reset empties the queue and idles the converter; no result
// is pending after reset. Results leave in input order.
module days_to_civil_date #(
  parameter int unsigned DAY_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [DAY_BITS-1:0]          day_count,
  output logic                         busy,
  output logic                         done,
  output logic [dtcd_pkg::YEAR_W-1:0]  year,
  output logic [dtcd_pkg::MONTH_W-1:0] month,
  output logic [dtcd_pkg::DAY_W-1:0]   day
);
  import dtcd_pkg::*;

  logic                pop;
  logic                avail;
  logic [DAY_BITS-1:0] head;

  // Front: accepts transactions into the queue
  dtcd_front #(
    .DAY_BITS (DAY_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .day_count (day_count),
    .busy      (busy),
    .pop       (pop),
    .avail     (avail),
    .head      (head)
  );

  // Back: year loop then month loop, one result strobe per transaction
  dtcd_back #(
    .DAY_BITS (DAY_BITS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (avail),
    .head  (head),
    .pop   (pop),
    .done  (done),
    .year  (year),
    .month (month),
    .day   (day)
  );

endmodule

// ===== rtl/dtcd_front.sv =====
// Accept side of the converter: takes transactions and holds them in a
// short queue. Depends on dtcd_pkg.
module dtcd_front #(
  parameter int unsigned DAY_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DAY_BITS-1:0] day_count,
  output logic                busy,
  input  logic                pop,
  output logic                avail,
  output logic [DAY_BITS-1:0] head
);
  import dtcd_pkg::*;

  logic [DAY_BITS-1:0] q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;

  assign busy  = (count == QCNT_W'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign push  = start && !busy;
  assign head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= day_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/dtcd_back.sv =====
// Iterative converter: strips one year per cycle, then one month per cycle.
// Depends on dtcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dtcd_back #(
  parameter int unsigned DAY_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         avail,
  input  logic [DAY_BITS-1:0]          head,
  output logic                         pop,
  output logic                         done,
  output logic [dtcd_pkg::YEAR_W-1:0]  year,
  output logic [dtcd_pkg::MONTH_W-1:0] month,
  output logic [dtcd_pkg::DAY_W-1:0]   day
);
  import dtcd_pkg::*;

  cvt_state_t           state, state_next;
  logic [DAY_BITS-1:0]  days, days_next;
  logic [YEAR_W-1:0]    yr, yr_next;
  logic [MOD4_W-1:0]    m4, m4_next;
  logic [MOD100_W-1:0]  m100, m100_next;
  logic [MOD400_W-1:0]  m400, m400_next;
  logic [MONTH_W-1:0]   mon, mon_next;
  logic                 done_next;

  logic                 leap;
  logic [YLEN_W-1:0]    ylen;
  logic [DAY_W-1:0]     mlen;
  logic                 year_fits;
  logic                 month_fits;

  // Leap rule from running residues, no division needed
  assign leap = ((m4 == '0) && (m100 != '0)) || (m400 == '0);
  assign ylen = leap ? YLEN_W'(DAYS_LEAP) : YLEN_W'(DAYS_COMMON);
  assign mlen = month_len(mon, leap);
  assign year_fits  = (days >= DAY_BITS'(ylen));
  assign month_fits = (days >= DAY_BITS'(mlen)) && (mon != MON_DEC);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (avail) state_next = ST_YEAR;
      ST_YEAR:  if (!year_fits) state_next = ST_MONTH;
      ST_MONTH: if (!month_fits) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    pop       = 1'b0;
    done_next = 1'b0;
    days_next = days;
    yr_next   = yr;
    m4_next   = m4;
    m100_next = m100;
    m400_next = m400;
    mon_next  = mon;
    case (state)
      ST_IDLE: begin
        if (avail) begin
          pop       = 1'b1;
          days_next = head;
          yr_next   = YEAR_W'(EPOCH_YEAR);
          m4_next   = EPOCH_MOD4;
          m100_next = EPOCH_MOD100;
          m400_next = EPOCH_MOD400;
        end
      end
      ST_YEAR: begin
        mon_next = MON_JAN;
        if (year_fits) begin
          days_next = days - DAY_BITS'(ylen);
          yr_next   = yr + 1'b1;
          m4_next   = m4 + 1'b1;
          m100_next = (m100 == MOD100_W'(CENTURY - 1)) ? '0 : m100 + 1'b1;
          m400_next = (m400 == MOD400_W'(QUAD_CENT - 1)) ? '0 : m400 + 1'b1;
        end
      end
      ST_MONTH: begin
        if (month_fits) begin
          days_next = days - DAY_BITS'(mlen);
          mon_next  = mon + 1'b1;
        end else begin
          done_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    days <= days_next;
    yr   <= yr_next;
    m4   <= m4_next;
    m100 <= m100_next;
    m400 <= m400_next;
    mon  <= mon_next;
    if (done_next) begin
      year  <= yr;
      month <= mon;
      day   <= days[DAY_W-1:0] + 1'b1;
    end
  end

  `ASSERT_CLK(a_done_after_month, clk, rst, done |-> $past(state) == ST_MONTH)
  `ASSERT_CLK(a_pop_starts_years, clk, rst, pop |=> state == ST_YEAR)
  `ASSERT_CLK(a_month_range, clk, rst,
              (state == ST_MONTH) |-> (mon >= MON_JAN && mon <= MON_DEC))
  `ASSERT_NEVER(a_month_rem_short, clk, rst,
                (state == ST_MONTH) && (days >= DAY_BITS'(DAYS_LEAP)))

endmodule

// ===== verif/civil_date_checker.sv =====
`timescale 1ns / 100ps
// Checker for days_to_civil_date: predicts the date of each accepted day count
// and compares it with the next result strobe. Depends on dtcd_pkg.
module civil_date_checker
  import dtcd_pkg::*;
#(
  parameter int unsigned DAY_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [DAY_BITS-1:0] day_count,
  input  logic                done,
  input  logic [YEAR_W-1:0]   year,
  input  logic [MONTH_W-1:0]  month,
  input  logic [DAY_W-1:0]    day,
  output int                  errors,
  output int                  pending,
  output int                  checked
);

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } civil_date_t;

  // Common-year month lengths, January first
  int unsigned common_month_days [0:11] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  civil_date_t expected_dates [$];
  int          mismatch_cnt = 0;
  int          result_cnt = 0;

  function automatic bit gregorian_leap(input int unsigned y);
    return ((y % LEAP_CYCLE) == 0 && (y % CENTURY) != 0) || (y % QUAD_CENT) == 0;
  endfunction

  function automatic civil_date_t civil_date_of(input logic [DAY_BITS-1:0] count);
    int unsigned rem;
    int unsigned yr;
    int unsigned mon;
    int unsigned ylen;
    int unsigned mlen;
    civil_date_t d;
    rem = count;
    yr  = EPOCH_YEAR;
    mon = 1;
    ylen = gregorian_leap(yr) ? DAYS_LEAP : DAYS_COMMON;
    while (rem >= ylen) begin
      rem -= ylen;
      yr++;
      ylen = gregorian_leap(yr) ? DAYS_LEAP : DAYS_COMMON;
    end
    while (mon < MON_DEC) begin
      mlen = common_month_days[mon-1];
      if (MONTH_W'(mon) == MON_FEB && gregorian_leap(yr)) mlen++;
      if (rem < mlen) break;
      rem -= mlen;
      mon++;
    end
    d.year  = YEAR_W'(yr);
    d.month = MONTH_W'(mon);
    d.day   = DAY_W'(rem + 1);
    return d;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    civil_date_t want;
    if (!rst) begin
      // Retire first: a result never belongs to a transaction taken at the same edge.
      if (done) begin
        if (expected_dates.size() == 0) begin
          $error("result %0d/%0d/%0d with no transaction outstanding", year, month, day);
          mismatch_cnt++;
        end else begin
          want = expected_dates.pop_front();
          result_cnt++;
          if (year !== want.year) begin
            $error("year: expected %0d, got %0d", want.year, year);
            mismatch_cnt++;
          end
          if (month !== want.month) begin
            $error("month: expected %0d, got %0d", want.month, month);
            mismatch_cnt++;
          end
          if (day !== want.day) begin
            $error("day: expected %0d, got %0d", want.day, day);
            mismatch_cnt++;
          end
        end
      end
      if (start && !busy) expected_dates.push_back(civil_date_of(day_count));
    end
    errors  <= mismatch_cnt;
    pending <= expected_dates.size();
    checked <= result_cnt;
  end

endmodule

// ===== verif/days_to_civil_date_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for days_to_civil_date: drives day counts, hosts the checker
// and reports the verdict. Depends on dtcd_pkg, the RTL and civil_date_checker.
module days_to_civil_date_tb;
  import dtcd_pkg::*;

  localparam int unsigned DAY_BITS = 20;
  // A start can sit behind one full conversion plus a sender gap; the
  // limit leaves a wide margin over the slowest conversion.
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 39;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic [DAY_BITS-1:0] day_count;
  logic                busy;
  logic                done;
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;

  int errors;
  int pending;
  int checked;
  int sent = 0;
  int stall_cycles = 0;

  // Corner dates: epoch, month and year edges of 1970, first leap day (1972),
  // end of a leap year, the 1999/2000 rollover and its leap day, the
  // non-leap century 2100, top bit alone and all input bits set.
  int unsigned corner_days [0:22] = '{
    0, 1, 30, 31, 58, 59, 333, 364, 365, 729, 730, 789, 790, 1095,
    10956, 10957, 11016, 11017, 47481, 47482, 47541, 524288, 1048575
  };

  always #5 clk = ~clk;

  days_to_civil_date #(.DAY_BITS(DAY_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .day_count(day_count),
    .busy     (busy),
    .done     (done),
    .year     (year),
    .month    (month),
    .day      (day)
  );

  civil_date_checker #(.DAY_BITS(DAY_BITS)) checker_i (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .day_count(day_count),
    .done     (done),
    .year     (year),
    .month    (month),
    .day      (day),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  // Watchdog: any cycle without a command or result transaction counts.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("days_to_civil_date_tb: done, errors");
      $finish;
    end
  end

  // Mostly full-range counts (up to ~2870 years of work each), some in the
  // first two centuries to keep runs short, a few at the very top.
  function automatic logic [DAY_BITS-1:0] pick_day_count();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel <= 5) return DAY_BITS'($urandom);
    if (sel <= 8) return DAY_BITS'($urandom_range(73000));
    return DAY_BITS'($urandom_range((1 << DAY_BITS) - 1, (1 << DAY_BITS) - 1024));
  endfunction

  // One command transaction. Idle cycles drive junk on day_count with start
  // low; then start is held until an edge sees busy low. start is left high
  // so back-to-back sends get a single assignment per step.
  task automatic send_day_count(input logic [DAY_BITS-1:0] value, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start     <= 1'b0;
      day_count <= DAY_BITS'($urandom);
      @(posedge clk);
    end
    start     <= 1'b1;
    day_count <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // Drop start and hold off until every outstanding transaction has returned.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int idle_pct [0:2];
    idle_pct = '{0, 56, 10};
    rst       <= 1'b1;
    start     <= 1'b0;
    day_count <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners, back to back
    foreach (corner_days[i]) send_day_count(DAY_BITS'(corner_days[i]), 0);
    drain_results();

    // Random phases: no gaps, heavy gaps, light gaps; fully drained between
    for (int p = 0; p < 3; p++) begin
      repeat (PHASE_ITEMS) send_day_count(pick_day_count(), idle_pct[p]);
      drain_results();
    end

    // Nothing can arrive without a transaction outstanding; short settle
    repeat (10) @(posedge clk);

    $display("days_to_civil_date_tb: %0d day counts converted (23 corner dates, %0d random)",
             sent, sent - 23);
    $display("days_to_civil_date_tb: %0d results compared over three sender-gap phases",
             checked);
    if (errors == 0 && pending == 0) begin
      $display("days_to_civil_date_tb: done, clean");
    end else begin
      $display("days_to_civil_date_tb: done, errors");
    end
    $finish;
  end

endmodule
